// ----- sv/dscb_pkg.sv -----
`default_nettype none

package dscb_pkg;

    // Opcodes of an input beat
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Status codes of a result beat
    localparam logic [1:0] STAT_ACCEPTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_ENTRY    = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [1:0]        kind;
        logic [31:0]       handle;
        logic signed [31:0] depth_key;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        out_kind;
        logic [31:0]       out_handle;
        logic signed [31:0] out_depth;
        logic              last;
    } t_out;

    // One stored entry
    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       handle;
        logic signed [31:0] key;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;   // insert the broadcast entry
        logic pop;    // shift everything one slot toward cell 0
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- sv/dscb_cell.sv -----
`default_nettype none

module dscb_cell (
    input  wire                  i_clk,
    input  dscb_pkg::t_cell_ctrl i_ctrl,
    input  dscb_pkg::t_entry     i_new,
    input  dscb_pkg::t_entry     i_left,
    input  wire                  i_left_gt,
    input  wire                  i_left_valid,
    input  wire                  i_valid,
    input  dscb_pkg::t_entry     i_right,
    output dscb_pkg::t_entry     o_entry,
    output logic                 o_gt
);

    dscb_pkg::t_entry r_entry;
    dscb_pkg::t_entry n_entry;

    // Stored key strictly above the new key: this slot moves up on a push
    assign o_gt    = i_valid && ($signed(r_entry.key) > $signed(i_new.key));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.pop) begin
            n_entry = i_right;
        end else if (i_ctrl.push) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else if (i_left_valid && (o_gt || !i_valid)) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ----- sv/depth_sorted_command_buffer.sv -----
`default_nettype none

// Channel  Direction  Payload            Handshake
// in       input      dscb_pkg::t_in     i_in_valid / o_in_stall
// out      output     dscb_pkg::t_out    o_out_valid / i_out_stall
//
// On a push all cells compare against the new key at once and the row
// shifts right past the insert point; a push can follow every cycle while
// the output is not stalled. A flush of N entries is accepted, then pops
// one beat per cycle from cell 0 while the row shifts left unless the output
// is stalled; input stays stalled until the last beat is loaded.
// Reset clears the entry count, the output valid and the control state only.
// Output stall holds the result register and stalls the input side with it.
module depth_sorted_command_buffer #(
    parameter int CAPACITY = 64
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  dscb_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    output dscb_pkg::t_out o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FLUSH = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    dscb_pkg::t_out   r_out, n_out;

    dscb_pkg::t_cell_ctrl w_ctrl;
    dscb_pkg::t_entry     w_new;
    dscb_pkg::t_entry     w_entry [CAPACITY];
    logic [CAPACITY-1:0]  w_gt;
    logic [CAPACITY-1:0]  w_valid;

    logic w_out_free;
    logic w_in_acc;
    logic w_full;

    // Result register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && w_out_free);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == FULL_CNT);

    assign w_new.kind   = i_in.kind;
    assign w_new.handle = i_in.handle;
    assign w_new.key    = i_in.depth_key;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_ctrl      = '{push: 1'b0, pop: 1'b0};

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_out = '0;
                    if (i_in.opcode == dscb_pkg::OP_PUSH) begin
                        n_out_valid = 1'b1;
                        n_out.last  = 1'b1;
                        if (w_full) begin
                            n_out.status = dscb_pkg::STAT_FULL;
                        end else begin
                            n_out.status = dscb_pkg::STAT_ACCEPTED;
                            w_ctrl.push  = 1'b1;
                            n_count      = r_count + ONE_CNT;
                        end
                    end else if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out.status = dscb_pkg::STAT_EMPTY;
                        n_out.last   = 1'b1;
                    end else begin
                        // Beats come out of the flush state, one per cycle while the output is not stalled
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = dscb_pkg::STAT_ENTRY;
                    n_out.out_kind   = w_entry[0].kind;
                    n_out.out_handle = w_entry[0].handle;
                    n_out.out_depth  = w_entry[0].key;
                    n_out.last       = (r_count == ONE_CNT);
                    w_ctrl.pop       = 1'b1;
                    n_count          = r_count - ONE_CNT;
                    if (r_count == ONE_CNT) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Row of cells: cell i holds the i-th smallest key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dscb_pkg::t_entry w_left;
        dscb_pkg::t_entry w_right;
        logic             w_left_gt;
        logic             w_left_valid;

        assign w_valid[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign w_left       = w_new;
            assign w_left_gt    = 1'b0;
            assign w_left_valid = 1'b1;
        end else begin : g_inner
            assign w_left       = w_entry[g-1];
            assign w_left_gt    = w_gt[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        dscb_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_new        (w_new),
            .i_left       (w_left),
            .i_left_gt    (w_left_gt),
            .i_left_valid (w_left_valid),
            .i_valid      (w_valid[g]),
            .i_right      (w_right),
            .o_entry      (w_entry[g]),
            .o_gt         (w_gt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Entry count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    // Flush state only runs while entries remain
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_count != '0))
        else $error("flush state with empty buffer");

    // Push into a full buffer answers full and leaves the count alone
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.opcode == dscb_pkg::OP_PUSH) && w_full) |=>
            (o_out_valid && (o_out.status == dscb_pkg::STAT_FULL)
             && (r_count == FULL_CNT)))
        else $error("full push not rejected");

    // Last flushed beat empties the buffer
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FLUSH) && w_out_free && (r_count == ONE_CNT)) |=>
            (o_out.last && (r_count == '0) && (r_state == ST_IDLE)))
        else $error("flush end mismatch");

endmodule

`default_nettype wire

// ----- bench/tb_depth_sorted_command_buffer.sv -----
`default_nettype none

module tb_depth_sorted_command_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    // One queued command: the beat, whether to hold it until every
    // outstanding result has drained, and whether its batch runs gap-free.
    typedef struct {
        dscb_pkg::t_in beat;
        bit            hold;
        bit            calm;
    } t_draw_cmd;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    dscb_pkg::t_in  i_in        = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    dscb_pkg::t_out o_out;

    t_draw_cmd        queued_cmds[$];    // commands not yet presented
    dscb_pkg::t_entry sorted_entries[$]; // shadow of the buffer, ascending by key
    dscb_pkg::t_out   due_results[$];    // result beats still owed by the block

    int mismatch_cnt = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int cycle_cnt    = 0;

    depth_sorted_command_buffer #(
        .CAPACITY(DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input dscb_pkg::t_out got,
                                   input dscb_pkg::t_out want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic add_cmd(input logic op, input logic [1:0] kind,
                           input logic [31:0] handle, input logic [31:0] key,
                           input bit hold, input bit calm);
        t_draw_cmd c;
        c.beat.opcode    = op;
        c.beat.kind      = kind;
        c.beat.handle    = handle;
        c.beat.depth_key = key;
        c.hold           = hold;
        c.calm           = calm;
        queued_cmds.push_back(c);
    endtask

    // Predict the result beats of one accepted command and update the shadow.
    task automatic apply_command(input dscb_pkg::t_in cmd);
        dscb_pkg::t_entry ent;
        dscb_pkg::t_out   res;
        int               pos;
        res      = '0;
        res.last = 1'b1;
        if (cmd.opcode == dscb_pkg::OP_PUSH) begin
            if (sorted_entries.size() >= DEPTH) begin
                res.status = dscb_pkg::STAT_FULL;     // dropped, buffer unchanged
            end else begin
                ent.kind   = cmd.kind;
                ent.handle = cmd.handle;
                ent.key    = cmd.depth_key;
                // walk back only past strictly larger keys: ties stay in order
                pos = sorted_entries.size();
                while (pos > 0 &&
                       $signed(sorted_entries[pos-1].key) > $signed(cmd.depth_key))
                    pos--;
                sorted_entries.insert(pos, ent);
                res.status = dscb_pkg::STAT_ACCEPTED;
            end
            due_results.push_back(res);
        end else if (sorted_entries.size() == 0) begin
            res.status = dscb_pkg::STAT_EMPTY;
            due_results.push_back(res);
        end else begin
            foreach (sorted_entries[i]) begin
                res.status     = dscb_pkg::STAT_ENTRY;
                res.out_kind   = sorted_entries[i].kind;
                res.out_handle = sorted_entries[i].handle;
                res.out_depth  = sorted_entries[i].key;
                res.last       = (i == sorted_entries.size() - 1);
                due_results.push_back(res);
            end
            sorted_entries.delete();
        end
    endtask

    // Driver: predicts on each accepted beat, then loads the next command
    // unless a gap is running or the command must wait for a full drain.
    // Payload and valid only move when the current beat is not stalled.
    always @(posedge i_clk) begin : drive
        int r;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                apply_command(i_in);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (queued_cmds.size() != 0 &&
                             !(queued_cmds[0].hold && due_results.size() != 0)) begin
                    i_in       <= queued_cmds[0].beat;
                    i_in_valid <= 1'b1;
                    // gap before the following beat: mostly none, a few long
                    r = $urandom_range(0, 99);
                    if (queued_cmds[0].calm || r < 60)
                        gap_left = 0;
                    else if (r < 90)
                        gap_left = $urandom_range(1, 3);
                    else
                        gap_left = $urandom_range(8, 40);
                    void'(queued_cmds.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result beat against the oldest
    // prediction, and drives random output stall. No new stall starts while
    // bits 9:8 of the cycle counter are zero.
    always @(posedge i_clk) begin : watch
        dscb_pkg::t_out want;
        int             r;
        if (i_rst_n) begin
            cycle_cnt++;
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected beat", o_out, '0);
                end else begin
                    want = due_results.pop_front();
                    if (o_out.status !== want.status)
                        report_mismatch("status", o_out, want);
                    if (o_out.out_kind !== want.out_kind)
                        report_mismatch("out_kind", o_out, want);
                    if (o_out.out_handle !== want.out_handle)
                        report_mismatch("out_handle", o_out, want);
                    if (o_out.out_depth !== want.out_depth)
                        report_mismatch("out_depth", o_out, want);
                    if (o_out.last !== want.last)
                        report_mismatch("last", o_out, want);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (cycle_cnt[9:8] != 2'd0) begin
                    r = $urandom_range(0, 99);
                    if (r < 20)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 24)
                        stall_left = $urandom_range(8, 30);
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stim
        int          n_push;
        int          n_random;
        int          r;
        bit          calm;
        bit          hold;
        bit          first;
        logic [31:0] key;

        // Directed: flush of empty buffer (three times), key extremes, ties at
        // the extremes and at zero, kind 3, handle extremes, Q16.16 +-1.0.
        add_cmd(dscb_pkg::OP_FLUSH, 2'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_FLUSH, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd2, 32'h0000_1234, 32'h8000_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd3, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd0, 32'h5A5A_5A5A, 32'h0000_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd2, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd1, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd0, 32'h0000_0002, 32'h0000_0001, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd3, 32'h0000_0003, 32'h0001_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd0, 32'h0000_0004, 32'hFFFF_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_FLUSH, 2'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_FLUSH, 2'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_PUSH,  2'd3, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        add_cmd(dscb_pkg::OP_FLUSH, 2'd2, 32'hDEAD_0000, 32'h1234_5678, 1'b0, 1'b0);

        // Random batches of pushes closed by a flush. The first batch
        // overfills the buffer after a full drain; later ones are mostly
        // short, some medium, a few around capacity.
        n_random = 0;
        first    = 1'b1;
        hold     = 1'b1;
        while (n_random < 210) begin
            r = $urandom_range(0, 99);
            if (first)
                n_push = DEPTH + 2;
            else if (r < 65)
                n_push = $urandom_range(0, 8);
            else if (r < 90)
                n_push = $urandom_range(9, 30);
            else
                n_push = $urandom_range(DEPTH - 4, DEPTH + 4);
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n_push; i++) begin
                // keys: narrow range for ties, full range, or extremes
                case ($urandom_range(0, 2))
                    0: key = $urandom_range(0, 6) - 3;
                    1: key = $urandom;
                    default: begin
                        case ($urandom_range(0, 3))
                            0: key = 32'h8000_0000;
                            1: key = 32'h7FFF_FFFF;
                            2: key = 32'h0000_0000;
                            default: key = 32'hFFFF_FFFF;
                        endcase
                    end
                endcase
                add_cmd(dscb_pkg::OP_PUSH, 2'($urandom_range(0, 3)), $urandom, key,
                        hold, calm);
                hold = 1'b0;
            end
            add_cmd(dscb_pkg::OP_FLUSH, 2'($urandom_range(0, 3)), $urandom, $urandom,
                    hold, calm);
            n_random += n_push + 1;
            // occasional stray flush right behind: always empty
            if ($urandom_range(0, 9) == 0) begin
                add_cmd(dscb_pkg::OP_FLUSH, 2'($urandom_range(0, 3)), $urandom,
                        $urandom, 1'b0, calm);
                n_random++;
            end
            first = 1'b0;
            hold  = ($urandom_range(0, 19) == 0);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Run until every command is in and every result is out, then
        // allow a full flush worth of cycles for anything extra.
        while (queued_cmds.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 16) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
